// File: hdl/sgdf_pkg.sv
// Shared constants for the Savitzky-Golay derivative filter unit.
// No dependencies; imported by the top level and by the checker.
`timescale 1ns / 1ps

package sgdf_pkg;

    // Default build-time configuration.
    localparam int WINDOW_DEF         = 9;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Widths fixed by the item formats.
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 18;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 56;

    // Register map.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_FILTER_MODE = 1'b0;

    // Filter modes.
    typedef enum logic {
        MODE_DIFF = 1'b0,
        MODE_SG   = 1'b1
    } t_filter_mode;

endpackage

// File: hdl/savitzky_golay_derivative_filter_unit.sv
// Top level of the Savitzky-Golay derivative filter unit.
// Depends on sgdf_pkg (constants, mode type).
`timescale 1ns / 1ps

// Usage
// The slave stream takes one signed 16-bit sample per item in s_axis_tdata, with
// s_axis_tlast marking the final sample of a record. The master stream gives
// result items carrying the smoothed value, first derivative and twice the second
// derivative, with m_axis_tlast on the final result of a record. The APB port
// holds one register, filter_mode at address 0: 0 selects the lagged difference,
// 1 (reset value) the cubic Savitzky-Golay filter. Write it only while idle.
// A result passes from its accepted sample through an input history register,
// a registered product stage, a registered adder stage and an eight-entry result
// queue. One sample is taken per cycle while s_axis_tready is high; the last
// sample of a record in Savitzky-Golay mode releases up to half a window of extra
// zero results, which the queue drains one per cycle while m_axis_tready is high.
// s_axis_tready falls only when the queue together with the items still in the
// pipeline would fill it, so it never depends combinationally on m_axis_tready.
// When the receiver stalls, the head result holds steady and input continues
// until the queue is full.
// Reset clears the sample history, the sample count, the pipeline and the queue,
// and returns filter_mode to Savitzky-Golay.

module savitzky_golay_derivative_filter_unit
    import sgdf_pkg::*;
#(
    parameter int WINDOW         = WINDOW_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave stream: tdata = sample[15:0]; tlast = last.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    // Master stream: tdata = smoothed[17:0], first_derivative[35:18],
    // second_derivative[53:36], zero padding[55:54]; tlast = end_of_record.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int HALF   = (WINDOW - 1) / 2;
    localparam int TAPS   = 2 * HALF + 1;
    localparam int N_W    = $clog2(WINDOW + 1);
    localparam int RES_W  = $clog2(HALF + 2);
    localparam int TAP_W  = COEF_FRAC_BITS + 2;
    localparam int PROD_W = TAP_W + SAMPLE_W;
    localparam int SUM_W  = PROD_W + $clog2(TAPS);
    localparam int Q_W    = SUM_W - COEF_FRAC_BITS + 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 4);

    // Coefficient denominators of the cubic Savitzky-Golay rationals.
    localparam longint M      = WINDOW;
    localparam longint M2     = M * M;
    localparam longint M4     = M2 * M2;
    localparam longint SCALE  = longint'(1) <<< COEF_FRAC_BITS;
    localparam longint DEN_D1 = M * (M2 - 1) * (3 * M4 - 39 * M2 + 108);
    localparam longint DEN_D2 = M * (M2 - 1) * (M2 - 4);
    localparam longint DEN_S  = 4 * M * (M2 - 4);

    localparam logic signed [SUM_W:0] RND_ADD =
        (SUM_W + 1)'(longint'(1) <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(131071);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-131072);

    typedef struct packed {
        logic             mode;
        logic             has_norm;
        logic             calc;
        logic             diff_ok;
        logic             last;
        logic [RES_W-1:0] nflush;
    } t_ctl;

    typedef struct packed {
        t_ctl                     ctl;
        logic signed [OUT_W-1:0]  s;
        logic signed [OUT_W-1:0]  d1;
        logic signed [OUT_W-1:0]  d2;
    } t_entry;

    // Divide by 2^COEF_FRAC_BITS with ties away from zero, then saturate.
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [SUM_W:0] biased;
        logic signed [Q_W-1:0] q;
        biased = {acc[SUM_W-1], acc} + RND_ADD
                 - {{SUM_W{1'b0}}, acc[SUM_W-1]};
        q = biased[SUM_W:COEF_FRAC_BITS];
        if (q > Q_MAX) begin
            return OUT_W'(Q_MAX);
        end else if (q < Q_MIN) begin
            return OUT_W'(Q_MIN);
        end
        return q[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    t_filter_mode r_mode;
    logic         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_FILTER_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SG;
        end else if (cfg_wr) begin
            r_mode <= t_filter_mode'(pwdata[0]);
        end
    end

    assign prdata = (paddr[2] == REG_IDX_FILTER_MODE)
                    ? {{(APB_DATA_W - 1){1'b0}}, r_mode} : '0;

    // ------------------------------------------------------------------
    // Input stage: sample history, sample count and per-item decisions.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] r_hist [0:WINDOW];
    logic [N_W-1:0]             r_seen;
    logic                       r_s0_valid;
    t_ctl                       r_s0_ctl;
    t_ctl                       n_s0_ctl;
    logic                       in_acc;
    logic                       in_last;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_last = s_axis_tlast;

    always_comb begin
        n_s0_ctl.mode     = r_mode;
        n_s0_ctl.last     = in_last;
        n_s0_ctl.diff_ok  = r_seen >= N_W'(WINDOW);
        n_s0_ctl.calc     = (r_mode == MODE_SG) && (r_seen >= N_W'(2 * HALF));
        n_s0_ctl.has_norm = (r_mode == MODE_DIFF) || (r_seen >= N_W'(HALF));
        n_s0_ctl.nflush   = '0;
        if ((r_mode == MODE_SG) && in_last) begin
            // A short record flushes only the centres it has seen.
            n_s0_ctl.nflush = (r_seen >= N_W'(HALF)) ? RES_W'(HALF)
                              : RES_W'(r_seen) + RES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= WINDOW; k++) begin
                r_hist[k] <= '0;
            end
            r_seen     <= '0;
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= in_acc;
            if (in_acc) begin
                r_hist[0] <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
                for (int k = 1; k <= WINDOW; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
                if (in_last) begin
                    r_seen <= '0;
                end else if (r_seen < N_W'(WINDOW)) begin
                    r_seen <= r_seen + N_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_ctl <= n_s0_ctl;
        end
    end

    // ------------------------------------------------------------------
    // Product stage: one constant multiplication per tap and output.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_prod_s  [TAPS];
    logic signed [PROD_W-1:0] r_prod_d1 [TAPS];
    logic signed [PROD_W-1:0] r_prod_d2 [TAPS];
    logic signed [DIFF_W-1:0] r_s1_diff;
    t_ctl                     r_s1_ctl;
    logic                     r_s1_valid;

    for (genvar t = 0; t < TAPS; t++) begin : g_tap
        localparam longint I = longint'(t) - HALF;
        localparam longint NUM_D1 =
            15 * (5 * (3 * M4 - 18 * M2 + 31) * I - 28 * (3 * M2 - 7) * I * I * I) * SCALE;
        localparam longint NUM_D2 = 30 * (12 * I * I - (M2 - 1)) * SCALE;
        localparam longint NUM_S  = 3 * (3 * M2 - 7 - 20 * I * I) * SCALE;
        localparam longint TAP_D1 = (NUM_D1 >= 0) ? (NUM_D1 + DEN_D1 / 2) / DEN_D1
                                    : -((-NUM_D1 + DEN_D1 / 2) / DEN_D1);
        localparam longint TAP_D2 = (NUM_D2 >= 0) ? (NUM_D2 + DEN_D2 / 2) / DEN_D2
                                    : -((-NUM_D2 + DEN_D2 / 2) / DEN_D2);
        localparam longint TAP_S  = (NUM_S >= 0) ? (NUM_S + DEN_S / 2) / DEN_S
                                    : -((-NUM_S + DEN_S / 2) / DEN_S);
        localparam logic signed [TAP_W-1:0] K_S  = TAP_W'(TAP_S);
        localparam logic signed [TAP_W-1:0] K_D1 = TAP_W'(TAP_D1);
        localparam logic signed [TAP_W-1:0] K_D2 = TAP_W'(2 * TAP_D2);

        // Tap t sees the sample 2*HALF-t places back from the newest.
        always_ff @(posedge i_clk) begin
            r_prod_s[t]  <= PROD_W'(K_S)  * PROD_W'(r_hist[2*HALF-t]);
            r_prod_d1[t] <= PROD_W'(K_D1) * PROD_W'(r_hist[2*HALF-t]);
            r_prod_d2[t] <= PROD_W'(K_D2) * PROD_W'(r_hist[2*HALF-t]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_diff <= DIFF_W'(r_hist[0]) - DIFF_W'(r_hist[WINDOW]);
        r_s1_ctl  <= r_s0_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    // ------------------------------------------------------------------
    // Adder stage.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  n_acc_s, n_acc_d1, n_acc_d2;
    logic signed [SUM_W-1:0]  r_acc_s, r_acc_d1, r_acc_d2;
    logic signed [DIFF_W-1:0] r_s2_diff;
    t_ctl                     r_s2_ctl;
    logic                     r_s2_valid;

    always_comb begin
        n_acc_s  = '0;
        n_acc_d1 = '0;
        n_acc_d2 = '0;
        for (int t = 0; t < TAPS; t++) begin
            n_acc_s  = n_acc_s  + SUM_W'(r_prod_s[t]);
            n_acc_d1 = n_acc_d1 + SUM_W'(r_prod_d1[t]);
            n_acc_d2 = n_acc_d2 + SUM_W'(r_prod_d2[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_s   <= n_acc_s;
        r_acc_d1  <= n_acc_d1;
        r_acc_d2  <= n_acc_d2;
        r_s2_diff <= r_s1_diff;
        r_s2_ctl  <= r_s1_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // ------------------------------------------------------------------
    // Rounding, saturation and the result queue.
    // ------------------------------------------------------------------
    t_entry           n_entry;
    t_entry           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] inflight;
    logic             fifo_wr, fifo_rd;

    always_comb begin
        n_entry.ctl = r_s2_ctl;
        n_entry.s   = '0;
        n_entry.d1  = '0;
        n_entry.d2  = '0;
        if (r_s2_ctl.mode == MODE_DIFF) begin
            if (r_s2_ctl.diff_ok) begin
                n_entry.d1 = OUT_W'(r_s2_diff);
            end
        end else if (r_s2_ctl.calc) begin
            n_entry.s  = round_sat(r_acc_s);
            n_entry.d1 = round_sat(r_acc_d1);
            n_entry.d2 = round_sat(r_acc_d2);
        end
    end

    // Items that yield no result (edge centres before the record fills) stop here.
    assign fifo_wr = r_s2_valid && (r_s2_ctl.has_norm || (r_s2_ctl.nflush != '0));

    always_ff @(posedge i_clk) begin
        if (fifo_wr) begin
            r_fifo[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (fifo_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (fifo_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(fifo_wr) - CNT_W'(fifo_rd);
        end
    end

    // Credit check: every item in the pipeline is sure of a queue slot.
    assign inflight = r_count + CNT_W'(r_s0_valid) + CNT_W'(r_s1_valid)
                      + CNT_W'(r_s2_valid);
    assign s_axis_tready = inflight < CNT_W'(FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Output expansion: the head entry gives its normal result, if any, and
    // then its flushed zero results.
    // ------------------------------------------------------------------
    t_entry           head;
    logic [RES_W-1:0] r_sub;
    logic [RES_W-1:0] last_sub;
    logic             show_vals;
    logic             out_acc;
    logic             at_end;

    assign head      = r_fifo[r_rd_ptr];
    assign last_sub  = RES_W'(head.ctl.has_norm) + head.ctl.nflush - RES_W'(1);
    assign at_end    = (r_sub == last_sub);
    assign show_vals = head.ctl.has_norm && (r_sub == '0);

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tlast  = head.ctl.last && at_end;
    assign m_axis_tdata  = show_vals ? {2'b00, head.d2, head.d1, head.s} : '0;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign fifo_rd = out_acc && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (out_acc) begin
            r_sub <= at_end ? '0 : r_sub + RES_W'(1);
        end
    end

endmodule

// File: hdl/sgdf_checker.sv
// Port-level checker for the Savitzky-Golay derivative filter unit, with its bind.
// Depends on sgdf_pkg for the stream widths.
`timescale 1ns / 1ps

module sgdf_checker
    import sgdf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // Reset empties the pipeline and the result queue.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // With nothing in flight after reset, the input side is open.
    a_reset_opens_input: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_stall_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

endmodule

bind savitzky_golay_derivative_filter_unit sgdf_checker u_sgdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
